// File: src/tlist_pkg.sv
package tlist_pkg;

    localparam int DATA_W = 32;

    typedef logic [DATA_W-1:0] data_t;
    typedef logic [2:0]        req_t;
    typedef logic [1:0]        status_t;

    // request codes
    localparam req_t REQ_APPEND = 3'd0;
    localparam req_t REQ_REMOVE = 3'd1;
    localparam req_t REQ_CLEAR  = 3'd2;
    localparam req_t REQ_PALIN  = 3'd3;
    localparam req_t REQ_SEARCH = 3'd4;

    // result status codes
    localparam status_t ST_DONE  = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

    localparam int COUNT_OUT_W = 9;

endpackage

// File: src/tlist_mem.sv
module tlist_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  tlist_pkg::data_t     wr_data,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr_a,
    input  logic [AW-1:0]        rd_addr_b,
    output tlist_pkg::data_t     rd_data_a,
    output tlist_pkg::data_t     rd_data_b
);
    import tlist_pkg::*;

    data_t entry_reg [DEPTH];
    data_t rd_a_reg;
    data_t rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_a_reg <= entry_reg[rd_addr_a];
            rd_b_reg <= entry_reg[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

// File: src/tlist_ctrl.sv
module tlist_ctrl #(
    parameter int CAPACITY = 256,
    parameter int AW       = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  tlist_pkg::req_t               req_type,
    input  logic signed [tlist_pkg::DATA_W-1:0] operand_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output tlist_pkg::status_t            status,
    output logic                          answer,
    output logic [tlist_pkg::COUNT_OUT_W-1:0] entry_count,
    output logic                          wr_en,
    output logic [AW-1:0]                 wr_addr,
    output tlist_pkg::data_t              wr_data,
    output logic                          rd_en,
    output logic [AW-1:0]                 rd_addr_a,
    output logic [AW-1:0]                 rd_addr_b,
    input  tlist_pkg::data_t              rd_data_a,
    input  tlist_pkg::data_t              rd_data_b
);
    import tlist_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hi_reg, hi_next;
    data_t         key_reg, key_next;
    logic          srch_reg, srch_next;
    logic          pend_reg, pend_next;
    logic          ans_reg, ans_next;
    logic          out_valid_reg, out_valid_next;
    status_t       status_reg, status_next;
    logic          answer_reg, answer_next;

    logic          out_free;
    logic          acc;
    logic          full;
    logic [CW:0]   lo_inc;
    logic [CW-1:0] hi_dec;
    logic          issue;
    logic          hit;
    logic [CW+COUNT_OUT_W-1:0] count_wide;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign acc      = in_valid && in_ready;
    assign full     = (count_reg == CW'(CAPACITY));

    assign lo_inc = {1'b0, lo_reg} + {{CW{1'b0}}, 1'b1};
    assign hi_dec = hi_reg - {{(CW-1){1'b0}}, 1'b1};

    // search walks lo up to hi; palindrome closes lo and hi towards each other
    assign issue = srch_reg ? (lo_reg < hi_reg) : ({1'b0, hi_reg} > lo_inc);
    assign hit   = pend_reg && (srch_reg ? (rd_data_a == key_reg)
                                         : (rd_data_a != rd_data_b));

    assign rd_en     = (state_reg == S_WALK) && issue;
    assign rd_addr_a = lo_reg[AW-1:0];
    assign rd_addr_b = hi_dec[AW-1:0];

    assign wr_en   = acc && (req_type == REQ_APPEND) && !full;
    assign wr_addr = count_reg[AW-1:0];
    assign wr_data = data_t'(operand_value);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        key_next       = key_reg;
        srch_next      = srch_reg;
        pend_next      = 1'b0;
        ans_next       = ans_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        answer_next    = answer_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    status_next = ST_DONE;
                    answer_next = 1'b0;
                    case (req_type)
                        REQ_APPEND:
                        begin
                            out_valid_next = 1'b1;
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + {{(CW-1){1'b0}}, 1'b1};
                            end
                        end
                        REQ_REMOVE:
                        begin
                            out_valid_next = 1'b1;
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - {{(CW-1){1'b0}}, 1'b1};
                            end
                        end
                        REQ_CLEAR:
                        begin
                            out_valid_next = 1'b1;
                            count_next     = '0;
                        end
                        REQ_PALIN:
                        begin
                            lo_next    = '0;
                            hi_next    = count_reg;
                            srch_next  = 1'b0;
                            state_next = S_WALK;
                        end
                        REQ_SEARCH:
                        begin
                            lo_next    = '0;
                            hi_next    = count_reg;
                            srch_next  = 1'b1;
                            key_next   = data_t'(operand_value);
                            state_next = S_WALK;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                pend_next = issue;
                if (issue)
                begin
                    lo_next = lo_inc[CW-1:0];
                    if (!srch_reg)
                    begin
                        hi_next = hi_dec;
                    end
                end
                // stop on the first match or mismatch, or once all reads are back
                if (hit || (!issue && !pend_reg))
                begin
                    ans_next   = srch_reg ? hit : !hit;
                    pend_next  = 1'b0;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = ST_DONE;
                    answer_next    = ans_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        key_reg    <= key_next;
        srch_reg   <= srch_next;
        ans_reg    <= ans_next;
        status_reg <= status_next;
        answer_reg <= answer_next;
    end

    assign count_wide  = (CW + COUNT_OUT_W)'(count_reg);
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign answer      = answer_reg;
    assign entry_count = count_wide[COUNT_OUT_W-1:0];

endmodule

// File: src/tail_list_with_search_and_palindrome_top.sv
// channel   handshake             payload
// request   in_valid / in_ready   req_type, operand_value
// result    out_valid / out_ready status, answer, entry_count
//
// append, remove, clear and unused codes: result registered in the cycle after the transfer
// search: one entry read per cycle, stops early on a hit
// palindrome: both ends read together on the two memory ports
// reset clears the count and the control state; the entry memory needs no clearing
// a held result stalls the next request only while the result register is still occupied
module tail_list_with_search_and_palindrome_top #(
    parameter int CAPACITY = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  tlist_pkg::req_t                    req_type,
    input  logic signed [tlist_pkg::DATA_W-1:0] operand_value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output tlist_pkg::status_t                 status,
    output logic                               answer,
    output logic [tlist_pkg::COUNT_OUT_W-1:0]  entry_count
);
    import tlist_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    data_t         wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr_a;
    logic [AW-1:0] rd_addr_b;
    data_t         rd_data_a;
    data_t         rd_data_b;

    tlist_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .operand_value (operand_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .answer        (answer),
        .entry_count   (entry_count),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .rd_en         (rd_en),
        .rd_addr_a     (rd_addr_a),
        .rd_addr_b     (rd_addr_b),
        .rd_data_a     (rd_data_a),
        .rd_data_b     (rd_data_b)
    );

    tlist_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

endmodule

// File: src/tlist_chk.sv
module tlist_chk (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input tlist_pkg::req_t                    req_type,
    input logic                               out_valid,
    input logic                               out_ready,
    input tlist_pkg::status_t                 status,
    input logic                               answer,
    input logic [tlist_pkg::COUNT_OUT_W-1:0]  entry_count
);
    import tlist_pkg::*;

    // a held result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(answer)
            && $stable(entry_count))
    else $error("result changed while stalled");

    // a new request is only taken when the result register can take its result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid || out_ready)
    else $error("request taken with result register occupied");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && req_type == REQ_CLEAR |=>
            out_valid && entry_count == '0 && status == ST_DONE && !answer)
    else $error("clear result wrong");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && req_type == REQ_APPEND |=>
            out_valid && !answer && (status == ST_DONE || status == ST_FULL))
    else $error("append result wrong");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && req_type == REQ_REMOVE |=>
            out_valid && !answer && (status == ST_DONE || status == ST_EMPTY))
    else $error("remove result wrong");

endmodule

bind tail_list_with_search_and_palindrome_top tlist_chk u_tlist_chk (.*);
